### hw/rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// Sizes, widths and controller/datapath command and status types for the
// Huffman code builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcb_pkg;

    localparam int LEAVES    = 8;
    localparam int NODES     = 2 * LEAVES - 1;
    localparam int LEAF_W    = $clog2(LEAVES);
    localparam int NODE_W    = $clog2(NODES);
    localparam int SYM_W     = 8;
    localparam int WEIGHT_W  = 10;
    // Room for the root weight: the sum of all leaf weights
    localparam int SUM_W     = WEIGHT_W + $clog2(LEAVES);
    localparam int CODE_W    = 7;
    localparam int LEN_OUT_W = 3;
    // Deepest leaf sits LEAVES-1 levels below the root
    localparam int LEN_W     = $clog2(LEAVES);

    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_step;
        logic merge_a;
        logic merge_b;
        logic walk_init;
        logic walk_step;
        logic emit;
        logic batch_clear;
    } t_cmd;

    typedef struct packed {
        logic last_load;
        logic scan_last;
        logic last_merge;
        logic at_root;
        logic last_leaf;
        logic out_free;
    } t_status;

endpackage

### hw/rtl/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// Node table, two-smallest scan, merge writes, leaf-to-root code walk and the
// result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcb_datapath
    import hcb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [WEIGHT_W-1:0]  i_weight,
    input  logic                 i_out_stall,
    output t_status              o_status,
    output logic                 o_valid,
    output logic [SYM_W-1:0]     o_out_symbol,
    output logic [CODE_W-1:0]    o_code_bits,
    output logic [LEN_OUT_W-1:0] o_code_length,
    output logic                 o_last
);

    // Node storage; entries are written before they are read
    logic [SUM_W-1:0]  r_weight [NODES];
    logic [NODE_W-1:0] r_parent [NODES];
    logic              r_side   [NODES];
    logic [SYM_W-1:0]  r_symbol [LEAVES];
    logic [NODES-1:0]  r_pvalid, n_pvalid;

    logic [LEAF_W-1:0] r_load_cnt, n_load_cnt;
    logic [NODE_W-1:0] r_new, n_new;
    logic [NODE_W-1:0] r_scan, n_scan;
    logic [NODE_W-1:0] r_a, n_a;
    logic [NODE_W-1:0] r_b, n_b;
    logic [SUM_W-1:0]  r_w1, n_w1;
    logic [SUM_W-1:0]  r_w2, n_w2;
    logic              r_have1, n_have1;
    logic              r_have2, n_have2;

    logic [NODE_W-1:0] r_ptr, n_ptr;
    logic [CODE_W-1:0] r_code, n_code;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEAF_W-1:0] r_leaf, n_leaf;

    logic                 r_out_valid, n_out_valid;
    logic [SYM_W-1:0]     r_out_sym;
    logic [CODE_W-1:0]    r_out_code;
    logic [LEN_OUT_W-1:0] r_out_len;
    logic                 r_out_last;

    logic [SUM_W-1:0] w_scan;
    logic             scan_free;
    logic             take1;
    logic             take2;
    logic [SUM_W-1:0] w_sum;

    assign w_scan    = r_weight[r_scan];
    assign scan_free = !r_pvalid[r_scan];
    // Strict compares keep ties on the lower index
    assign take1     = scan_free && (!r_have1 || (w_scan < r_w1));
    assign take2     = scan_free && !take1 && (!r_have2 || (w_scan < r_w2));
    assign w_sum     = r_w1 + r_w2;

    always_comb begin
        n_load_cnt  = r_load_cnt;
        n_new       = r_new;
        n_scan      = r_scan;
        n_a         = r_a;
        n_b         = r_b;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_have1     = r_have1;
        n_have2     = r_have2;
        n_pvalid    = r_pvalid;
        n_ptr       = r_ptr;
        n_code      = r_code;
        n_len       = r_len;
        n_leaf      = r_leaf;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.load) begin
            n_load_cnt = LEAF_W'(r_load_cnt + 1'b1);
        end
        if (i_cmd.scan_init) begin
            n_scan  = '0;
            n_have1 = 1'b0;
            n_have2 = 1'b0;
        end
        if (i_cmd.scan_step) begin
            n_scan = NODE_W'(r_scan + 1'b1);
            if (take1) begin
                n_w2    = r_w1;
                n_b     = r_a;
                n_have2 = r_have1;
                n_w1    = w_scan;
                n_a     = r_scan;
                n_have1 = 1'b1;
            end else if (take2) begin
                n_w2    = w_scan;
                n_b     = r_scan;
                n_have2 = 1'b1;
            end
        end
        if (i_cmd.merge_a) begin
            n_pvalid[r_a] = 1'b1;
        end
        if (i_cmd.merge_b) begin
            n_pvalid[r_b] = 1'b1;
            n_new         = NODE_W'(r_new + 1'b1);
        end
        if (i_cmd.walk_init) begin
            n_ptr  = NODE_W'(r_leaf);
            n_code = '0;
            n_len  = '0;
        end
        if (i_cmd.walk_step) begin
            // Leaf-side bit lands lowest, so the root-side bit ends up on top
            n_code = r_code | (CODE_W'(r_side[r_ptr]) << r_len);
            n_len  = LEN_W'(r_len + 1'b1);
            n_ptr  = r_parent[r_ptr];
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_leaf      = LEAF_W'(r_leaf + 1'b1);
            n_ptr       = NODE_W'(LEAF_W'(r_leaf + 1'b1));
            n_code      = '0;
            n_len       = '0;
        end
        if (i_cmd.batch_clear) begin
            n_load_cnt = '0;
            n_leaf     = '0;
            n_new      = NODE_W'(LEAVES);
            n_pvalid   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt  <= '0;
            r_new       <= NODE_W'(LEAVES);
            r_have1     <= 1'b0;
            r_have2     <= 1'b0;
            r_pvalid    <= '0;
            r_leaf      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_load_cnt  <= n_load_cnt;
            r_new       <= n_new;
            r_have1     <= n_have1;
            r_have2     <= n_have2;
            r_pvalid    <= n_pvalid;
            r_leaf      <= n_leaf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_a    <= n_a;
        r_b    <= n_b;
        r_w1   <= n_w1;
        r_w2   <= n_w2;
        r_ptr  <= n_ptr;
        r_code <= n_code;
        r_len  <= n_len;
        if (i_cmd.emit) begin
            r_out_sym  <= r_symbol[r_leaf];
            r_out_code <= r_code;
            r_out_len  <= LEN_OUT_W'(r_len);
            r_out_last <= (r_leaf == LEAF_W'(LEAVES - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_symbol[r_load_cnt]         <= i_symbol;
            r_weight[NODE_W'(r_load_cnt)] <= SUM_W'(i_weight);
        end else if (i_cmd.merge_a) begin
            r_weight[r_new] <= w_sum;
        end
        if (i_cmd.merge_a) begin
            r_parent[r_a] <= r_new;
            r_side[r_a]   <= 1'b0;
        end else if (i_cmd.merge_b) begin
            r_parent[r_b] <= r_new;
            r_side[r_b]   <= 1'b1;
        end
    end

    assign o_status.last_load  = (r_load_cnt == LEAF_W'(LEAVES - 1));
    assign o_status.scan_last  = (r_scan == NODE_W'(r_new - 1'b1));
    assign o_status.last_merge = (r_new == NODE_W'(NODES - 1));
    assign o_status.at_root    = !r_pvalid[r_ptr];
    assign o_status.last_leaf  = (r_leaf == LEAF_W'(LEAVES - 1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_valid       = r_out_valid;
    assign o_out_symbol  = r_out_sym;
    assign o_code_bits   = r_out_code;
    assign o_code_length = r_out_len;
    assign o_last        = r_out_last;

endmodule

### hw/rtl/hcb_ctrl.sv
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for load, tree build (scan and two merge writes per new node)
// and per-leaf code walk and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcb_ctrl
    import hcb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_MERGE_A = 3'd2;
    localparam logic [2:0] S_MERGE_B = 3'd3;
    localparam logic [2:0] S_WALK    = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.last_load) begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_MERGE_A;
                end
            end
            S_MERGE_A: begin
                o_cmd.merge_a = 1'b1;
                n_state       = S_MERGE_B;
            end
            S_MERGE_B: begin
                o_cmd.merge_b   = 1'b1;
                o_cmd.scan_init = 1'b1;
                if (i_status.last_merge) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WALK: begin
                if (!i_status.at_root) begin
                    o_cmd.walk_step = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_leaf) begin
                        o_cmd.batch_clear = 1'b1;
                        n_state           = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

endmodule

### hw/rtl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// Takes a batch of 8 leaf requests (symbol, weight), builds the Huffman tree
// and returns one code request per leaf in load order, the final one flagged
// last. Leaves load one per cycle while input is not stalled. The build then
// adds 7 nodes; for each, the node table is scanned one node per cycle over
// all existing nodes (8 to 14), followed by two merge writes. Each result
// then walks parent pointers from its leaf up to the root, one level a
// cycle. The single-read node table scan sets the build time. Input is
// stalled from the last leaf of a batch until its last result has been
// registered.
// Ties pick the lower node index; the smaller node becomes bit 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_builder
    import hcb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [WEIGHT_W-1:0]  i_weight,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [SYM_W-1:0]     o_out_symbol,
    output logic [CODE_W-1:0]    o_code_bits,
    output logic [LEN_OUT_W-1:0] o_code_length,
    output logic                 o_last
);

    t_cmd    cmd;
    t_status status;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_stall)
    );

    hcb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_symbol      (i_symbol),
        .i_weight      (i_weight),
        .i_out_stall   (i_stall),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_out_symbol  (o_out_symbol),
        .o_code_bits   (o_code_bits),
        .o_code_length (o_code_length),
        .o_last        (o_last)
    );

endmodule

### hw/rtl/hcb_checker.sv
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks for the Huffman code builder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcb_checker
    import hcb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic [SYM_W-1:0]     i_symbol,
    input logic [WEIGHT_W-1:0]  i_weight,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [SYM_W-1:0]     o_out_symbol,
    input logic [CODE_W-1:0]    o_code_bits,
    input logic [LEN_OUT_W-1:0] o_code_length,
    input logic                 o_last
);

    // A held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_symbol) && $stable(o_code_bits)
            && $stable(o_code_length) && $stable(o_last))
        else $error("result changed while stalled");

    // No code bit above the code length
    a_code_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CODE_W'(o_code_bits >> o_code_length) == CODE_W'(0)))
        else $error("code bits beyond code length");

    // Mid-batch results only appear while loading is held off
    a_no_load_mid_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_stall)
        else $error("input open while batch results pending");

    // A taken last result is never followed at once by another last result
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && !i_stall |=> !(o_valid && o_last))
        else $error("back to back last results");

    // A non-last result that follows an accepted item with no result pending comes only while input is stalled
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid || o_last || o_stall)
        else $error("result without build after load");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (.*);
